// ===== rtl/core/pba_pkg.sv =====
package pba_pkg;

	localparam int MAX_CHUNKS_DEF = 256;

	localparam int CHUNK_W  = 13;
	localparam int NUM_W    = 9;
	localparam int OFF_W    = 20;
	localparam int STAT_W   = 2;
	localparam int PROD_W   = CHUNK_W + NUM_W;
	localparam int CFG_IX_W = 2;

	localparam logic [CHUNK_W-1:0] CHUNK_SIZE_RST = CHUNK_W'(64);
	localparam logic [NUM_W-1:0]   NUM_CHUNKS_RST = NUM_W'(2);

	localparam logic [PROD_W-1:0] OFFSET_MAX = PROD_W'(20'hFFFFF);

	localparam logic [CFG_IX_W-1:0] CFG_CHUNK_SIZE = 2'd0;
	localparam logic [CFG_IX_W-1:0] CFG_NUM_CHUNKS = 2'd1;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
	localparam logic [STAT_W-1:0] ST_EXHAUSTED    = 2'd1;
	localparam logic [STAT_W-1:0] ST_OUT_OF_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_QUEUE_FULL   = 2'd3;

	typedef struct packed {
		logic load;
		logic calc;
		logic commit;
	} pba_cmd_t;

	typedef struct packed {
		logic q_empty;
		logic q_full;
	} pba_stat_t;

endpackage

// ===== rtl/core/pool_block_allocator_core.sv =====
// Flow: an accepted word passes through the controller's accept, product and queue
// read, then decide steps; decide waits while the output stalls. No new word is
// taken until the last one commits, but the next word is taken while a result waits.
// Reset: arst_n clears control, queue pointers and fresh counter at once and loads
// chunk_size 64 and num_chunks 2; queue contents stay undefined until written.
module pool_block_allocator_core #(
	parameter int MAX_CHUNKS = pba_pkg::MAX_CHUNKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pba_pkg::CFG_IX_W-1:0]  cfg_index,
	input  logic [pba_pkg::CHUNK_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [pba_pkg::OFF_W-1:0]     free_offset,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pba_pkg::STAT_W-1:0]    status,
	output logic [pba_pkg::OFF_W-1:0]     block_offset
);
	import pba_pkg::*;

	pba_cmd_t  cmd;
	pba_stat_t stat;

	pba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	pba_dp #(
		.MAX_CHUNKS (MAX_CHUNKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.func         (func),
		.free_offset  (free_offset),
		.status       (status),
		.block_offset (block_offset),
		.stat         (stat)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in flight");

	a_zero_offset_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> block_offset == '0)
		else $error("nonzero offset with error status");

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.q_empty && stat.q_full))
		else $error("free queue both empty and full");

	a_commit_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !in_ready)
		else $error("result committed while idle");

endmodule

// ===== rtl/core/pba_ctrl.sv =====
module pba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output pba_pkg::pba_cmd_t cmd
);
	import pba_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_CALC   = 2'd1;
	localparam logic [1:0] S_DECIDE = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.load   = in_valid && in_ready;
	assign cmd.calc   = (state_q == S_CALC);
	assign cmd.commit = (state_q == S_DECIDE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/pba_dp.sv =====
module pba_dp #(
	parameter int MAX_CHUNKS = pba_pkg::MAX_CHUNKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pba_pkg::CFG_IX_W-1:0]  cfg_index,
	input  logic [pba_pkg::CHUNK_W-1:0]   cfg_data,
	input  pba_pkg::pba_cmd_t             cmd,
	input  logic                          func,
	input  logic [pba_pkg::OFF_W-1:0]     free_offset,
	output logic [pba_pkg::STAT_W-1:0]    status,
	output logic [pba_pkg::OFF_W-1:0]     block_offset,
	output pba_pkg::pba_stat_t            stat
);
	import pba_pkg::*;

	localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CHUNKS - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_CHUNKS);

	logic [CHUNK_W-1:0] chunk_size_q;
	logic [NUM_W-1:0]   num_chunks_q;
	logic [NUM_W-1:0]   fresh_idx_q;
	logic [IDX_W-1:0]   head_q;
	logic [IDX_W-1:0]   tail_q;
	logic [CNT_W-1:0]   count_q;

	logic [OFF_W-1:0]   mem [MAX_CHUNKS];
	logic [OFF_W-1:0]   rd_q;

	logic               func_q;
	logic [OFF_W-1:0]   offset_q;
	logic [PROD_W-1:0]  fresh_off_q;
	logic [PROD_W-1:0]  pool_bytes_q;

	logic [STAT_W-1:0]  status_q;
	logic [OFF_W-1:0]   block_offset_q;

	logic               q_empty;
	logic               q_full;
	logic [STAT_W-1:0]  res_status;
	logic [OFF_W-1:0]   res_offset;
	logic               do_pop;
	logic               do_push;
	logic               do_bump;

	assign q_empty      = (count_q == '0);
	assign q_full       = (count_q == FULL_CNT);
	assign stat.q_empty = q_empty;
	assign stat.q_full  = q_full;
	assign status       = status_q;
	assign block_offset = block_offset_q;

	always_comb begin
		res_status = ST_OK;
		res_offset = '0;
		do_pop     = 1'b0;
		do_push    = 1'b0;
		do_bump    = 1'b0;
		if (func_q == FUNC_ALLOC) begin
			if (!q_empty) begin
				res_offset = rd_q;
				do_pop     = 1'b1;
			end else if (fresh_idx_q >= num_chunks_q || fresh_off_q > OFFSET_MAX) begin
				res_status = ST_EXHAUSTED;
			end else begin
				res_offset = fresh_off_q[OFF_W-1:0];
				do_bump    = 1'b1;
			end
		end else begin
			if (PROD_W'(offset_q) >= pool_bytes_q) begin
				res_status = ST_OUT_OF_RANGE;
			end else if (q_full) begin
				res_status = ST_QUEUE_FULL;
			end else begin
				do_push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= CHUNK_SIZE_RST;
			num_chunks_q <= NUM_CHUNKS_RST;
			fresh_idx_q  <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_CHUNK_SIZE) begin
				chunk_size_q <= cfg_data;
			end
			if (cfg_we && cfg_index == CFG_NUM_CHUNKS) begin
				num_chunks_q <= cfg_data[NUM_W-1:0];
			end
			if (cmd.commit) begin
				if (do_bump) begin
					fresh_idx_q <= fresh_idx_q + NUM_W'(1);
				end
				if (do_pop) begin
					head_q  <= (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
					count_q <= count_q - CNT_W'(1);
				end
				if (do_push) begin
					tail_q  <= (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			offset_q <= free_offset;
		end
		if (cmd.calc) begin
			fresh_off_q  <= PROD_W'(fresh_idx_q) * PROD_W'(chunk_size_q);
			pool_bytes_q <= PROD_W'(chunk_size_q) * PROD_W'(num_chunks_q);
			rd_q         <= mem[head_q];
		end
		if (cmd.commit) begin
			status_q       <= res_status;
			block_offset_q <= res_offset;
			if (do_push) begin
				mem[tail_q] <= offset_q;
			end
		end
	end

endmodule

// ===== tb/sv/pool_block_allocator_core_test.sv =====
`timescale 1ns / 1ps

module pool_block_allocator_core_test;
	import pba_pkg::*;

	localparam logic [CFG_IX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_PCT = 30;

	typedef struct packed {
		logic [STAT_W-1:0] st;
		logic [OFF_W-1:0]  boff;
	} grant_t;

	typedef struct packed {
		logic                is_reg;
		logic [CFG_IX_W-1:0] reg_ix;
		logic [CHUNK_W-1:0]  reg_val;
		logic                fn;
		logic [OFF_W-1:0]    off;
		logic                typed;
		logic [STAT_W-1:0]   st;
		logic [OFF_W-1:0]    boff;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IX_W-1:0] cfg_index;
	logic [CHUNK_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic func;
	logic [OFF_W-1:0] free_offset;
	logic out_valid;
	logic out_ready;
	logic [STAT_W-1:0] status;
	logic [OFF_W-1:0] block_offset;

	logic [CHUNK_W-1:0] chunk_size_r;
	logic [NUM_W-1:0] num_chunks_r;
	logic [NUM_W-1:0] fresh_count;
	logic [OFF_W-1:0] free_fifo[$];
	grant_t grants_due[$];
	grant_t got;

	bit steady = 1'b0;
	int errors = 0;
	int n_words = 0;
	int n_results = 0;
	int n_reg_writes = 0;
	int n_phases = 0;
	int status_hits[4] = '{0, 0, 0, 0};
	int quiet = 0;

	vec_t vec_tbl[26] = '{
		'{1'b0, 2'd0, 13'd0, FUNC_ALLOC, 20'd0,       1'b1, ST_OK,           20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_ALLOC, 20'd0,       1'b1, ST_OK,           20'd64},
		'{1'b0, 2'd0, 13'd0, FUNC_ALLOC, 20'hFFFFF,   1'b1, ST_EXHAUSTED,    20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_FREE,  20'd128,     1'b1, ST_OUT_OF_RANGE, 20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_FREE,  20'hFFFFF,   1'b1, ST_OUT_OF_RANGE, 20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_FREE,  20'd64,      1'b1, ST_OK,           20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_FREE,  20'd1,       1'b1, ST_OK,           20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_FREE,  20'd64,      1'b1, ST_OK,           20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_ALLOC, 20'h5A5A5,   1'b0, ST_OK,           20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_ALLOC, 20'd0,       1'b0, ST_OK,           20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_ALLOC, 20'd0,       1'b0, ST_OK,           20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_ALLOC, 20'd0,       1'b1, ST_EXHAUSTED,    20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_FREE,  20'd127,     1'b0, ST_OK,           20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_ALLOC, 20'd0,       1'b0, ST_OK,           20'd0},
		'{1'b1, CFG_CHUNK_SIZE, 13'd0, FUNC_ALLOC, 20'd0, 1'b0, ST_OK,       20'd0},
		'{1'b1, CFG_NUM_CHUNKS, 13'd4, FUNC_ALLOC, 20'd0, 1'b0, ST_OK,       20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_ALLOC, 20'd0,       1'b0, ST_OK,           20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_ALLOC, 20'd0,       1'b0, ST_OK,           20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_ALLOC, 20'd0,       1'b1, ST_EXHAUSTED,    20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_FREE,  20'd0,       1'b1, ST_OUT_OF_RANGE, 20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_FREE,  20'hFFFFF,   1'b1, ST_OUT_OF_RANGE, 20'd0},
		'{1'b1, CFG_SPARE_A, 13'h1FFF, FUNC_ALLOC, 20'd0, 1'b0, ST_OK,       20'd0},
		'{1'b1, CFG_SPARE_B, 13'h1FFF, FUNC_ALLOC, 20'd0, 1'b0, ST_OK,       20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_ALLOC, 20'd0,       1'b1, ST_EXHAUSTED,    20'd0},
		'{1'b1, CFG_NUM_CHUNKS, 13'h1E05, FUNC_ALLOC, 20'd0, 1'b0, ST_OK,    20'd0},
		'{1'b0, 2'd0, 13'd0, FUNC_ALLOC, 20'd0,       1'b0, ST_OK,           20'd0}
	};

	pool_block_allocator_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.free_offset (free_offset),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.block_offset(block_offset)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic grant_t pool_step(input logic fn, input logic [OFF_W-1:0] off);
		grant_t g;
		logic [63:0] span;
		g.st = ST_OK;
		g.boff = '0;
		if (fn == FUNC_ALLOC) begin
			span = 64'(fresh_count) * 64'(chunk_size_r);
			if (free_fifo.size() > 0) begin
				g.boff = free_fifo.pop_front();
			end else if (fresh_count >= num_chunks_r || span > 64'(OFFSET_MAX)) begin
				g.st = ST_EXHAUSTED;
			end else begin
				fresh_count = fresh_count + 1'b1;
				g.boff = span[OFF_W-1:0];
			end
		end else begin
			span = 64'(chunk_size_r) * 64'(num_chunks_r);
			if (64'(off) >= span) begin
				g.st = ST_OUT_OF_RANGE;
			end else if (free_fifo.size() >= MAX_CHUNKS_DEF) begin
				g.st = ST_QUEUE_FULL;
			end else begin
				free_fifo.push_back(off);
			end
		end
		return g;
	endfunction

	function automatic logic [OFF_W-1:0] pick_offset();
		logic [63:0] pool;
		logic [63:0] cand;
		int unsigned r;
		pool = 64'(chunk_size_r) * 64'(num_chunks_r);
		r = $urandom_range(99);
		cand = 64'($urandom) & 64'hFFFFF;
		if (r < 60 && num_chunks_r != 0)
			cand = 64'($urandom_range(num_chunks_r - 1)) * 64'(chunk_size_r);
		else if (r < 80 && pool != 0)
			cand = 64'($urandom) % pool;
		if (cand > 64'(OFFSET_MAX))
			cand = 64'($urandom) & 64'hFFFFF;
		return cand[OFF_W-1:0];
	endfunction

	task automatic send_word(input logic fn, input logic [OFF_W-1:0] off, input logic typed,
			input logic [STAT_W-1:0] st, input logic [OFF_W-1:0] boff);
		grant_t g;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		free_offset <= off;
		g = pool_step(fn, off);
		if (typed) begin
			g.st = st;
			g.boff = boff;
		end
		grants_due.push_back(g);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_words++;
	endtask

	task automatic write_reg(input logic [CFG_IX_W-1:0] ix, input logic [CHUNK_W-1:0] val);
		in_valid <= 1'b0;
		while (grants_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ix;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (ix)
			CFG_CHUNK_SIZE: chunk_size_r = val;
			CFG_NUM_CHUNKS: num_chunks_r = val[NUM_W-1:0];
			default: ;
		endcase
		n_reg_writes++;
	endtask

	task automatic run_phase(input logic [CHUNK_W-1:0] csize, input logic [CHUNK_W-1:0] cnum,
			input int count, input int free_pct, input bit calm);
		logic fn;
		write_reg(CFG_CHUNK_SIZE, csize);
		write_reg(CFG_NUM_CHUNKS, cnum);
		steady = calm;
		for (int i = 0; i < count; i++) begin
			fn = ($urandom_range(99) < free_pct) ? FUNC_FREE : FUNC_ALLOC;
			send_word(fn, (fn == FUNC_FREE) ? pick_offset() : OFF_W'($urandom), 1'b0, ST_OK, '0);
		end
		steady = 1'b0;
		n_phases++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			status_hits[status]++;
			if (grants_due.size() == 0) begin
				errors++;
				$display("%0t: result word with none expected: status %0d offset 0x%05h",
					$time, status, block_offset);
			end else begin
				got = grants_due.pop_front();
				if (status !== got.st) begin
					errors++;
					$display("%0t: status expected %0d got %0d", $time, got.st, status);
				end
				if (block_offset !== got.boff) begin
					errors++;
					$display("%0t: block_offset expected 0x%05h got 0x%05h",
						$time, got.boff, block_offset);
				end
			end
		end
		out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("pool_block_allocator_core regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_ALLOC;
		free_offset = '0;
		out_ready = 1'b0;
		chunk_size_r = CHUNK_SIZE_RST;
		num_chunks_r = NUM_CHUNKS_RST;
		fresh_count = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vec_tbl[i]) begin
			if (vec_tbl[i].is_reg)
				write_reg(vec_tbl[i].reg_ix, vec_tbl[i].reg_val);
			else
				send_word(vec_tbl[i].fn, vec_tbl[i].off, vec_tbl[i].typed,
					vec_tbl[i].st, vec_tbl[i].boff);
		end

		run_phase(13'd64, 13'd16, 130, 50, 1'b0);
		run_phase(13'd1, 13'd511, 130, 50, 1'b0);
		run_phase(13'h1FFF, 13'd511, 170, 8, 1'b1);
		run_phase(13'd4096, 13'd256, 320, 95, 1'b0);
		run_phase(13'd64, 13'd0, 180, 10, 1'b0);

		in_valid <= 1'b0;
		while (grants_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d requests and %0d results: ok %0d, exhausted %0d, out of range %0d, queue full %0d",
			n_words, n_results, status_hits[ST_OK], status_hits[ST_EXHAUSTED],
			status_hits[ST_OUT_OF_RANGE], status_hits[ST_QUEUE_FULL]);
		$display("%0d register writes, %0d random phases, %0d mismatches",
			n_reg_writes, n_phases, errors);
		if (errors == 0)
			$display("pool_block_allocator_core regression: pass");
		else
			$display("pool_block_allocator_core regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/pba_pkg.sv
rtl/core/pba_ctrl.sv
rtl/core/pba_dp.sv
rtl/core/pool_block_allocator_core.sv
tb/sv/pool_block_allocator_core_test.sv
